/* sv/ewm_pkg.sv */
`timescale 1ns / 1ps

package ewm_pkg;

    localparam int MAX_EXPERTS = 8;
    localparam int EXPERT_W    = $clog2(MAX_EXPERTS);
    localparam int SYMBOL_W    = 8;
    localparam int ALPHABET    = 1 << SYMBOL_W;
    localparam int PROB_W      = 16;
    localparam int OP_W        = 3;
    localparam int CNT_W       = EXPERT_W + 1;
    localparam int ADDR_W      = EXPERT_W + SYMBOL_W;
    localparam int STORE_DEPTH = MAX_EXPERTS * ALPHABET;
    localparam int SUM_W       = 24;
    localparam int LW_W        = 24;
    localparam int ETA_W       = 16;
    localparam int EX_W        = PROB_W + 1;
    localparam int ESUM_W      = EX_W + EXPERT_W;
    localparam int LOGX_W      = ESUM_W;
    localparam int LOG_W       = 18;
    localparam int DIV_W       = PROB_W + SUM_W + EXPERT_W;
    localparam int EXP_STEPS   = 12;
    localparam int PADDR_W     = 4;

    localparam logic [PROB_W-1:0] W_RST = (MAX_EXPERTS == 1) ? {PROB_W{1'b1}} :
        PROB_W'((1 << PROB_W) / MAX_EXPERTS);
    localparam logic signed [LW_W-1:0] LW_RST = LW_W'(-($clog2(MAX_EXPERTS) * 4096));
    localparam logic signed [LW_W-1:0] LW_MIN = {1'b1, {(LW_W-1){1'b0}}};
    localparam logic signed [LW_W-1:0] LW_MAX = {1'b0, {(LW_W-1){1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_QUERY  = 3'd1,
        OP_UPDATE = 3'd2,
        OP_READ   = 3'd3,
        OP_RESET  = 3'd4
    } op_t;

    localparam logic [1:0] REG_EXPERTS = 2'd0;
    localparam logic [1:0] REG_ETA     = 2'd1;
    localparam logic [1:0] REG_FLOOR   = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR,
        S_Q_RD, S_Q_MUL, S_Q_ACC, S_Q_DIV, S_Q_WAIT,
        S_U_RD, S_U_LOG, S_U_LWAIT, S_U_MUL, S_U_ADD, S_U_MAX,
        S_U_EXP0, S_U_EXP, S_U_EXPSH, S_U_LSUM, S_U_LSWAIT, S_U_DIV, S_U_DWAIT,
        S_R_START, S_R_WAIT, S_RESULT
    } ewm_state_t;

    typedef logic [EXP_STEPS-1:0][31:0] exp_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] rem;
        res = '0;
        bt  = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Factors 2^-(2^-(k+1)) in Q.32, each the square root of the one before.
    function automatic exp_tab_t calc_exp_tab();
        exp_tab_t tab;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int k = 0; k < EXP_STEPS; k++) begin
            c = isqrt64(c << 32);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_C = calc_exp_tab();

endpackage

/* sv/ewm_if.sv */
`timescale 1ns / 1ps

interface ewm_in_if;
    import ewm_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [EXPERT_W-1:0] expert;
    logic [SYMBOL_W-1:0] symbol;
    logic [PROB_W-1:0]   prob;
    modport source (output valid, op, expert, symbol, prob, input ready);
    modport sink (input valid, op, expert, symbol, prob, output ready);
endinterface

interface ewm_out_if;
    import ewm_pkg::*;
    logic              valid;
    logic              ready;
    logic [PROB_W-1:0] value;
    logic              bad_index;
    modport source (output valid, value, bad_index, input ready);
    modport sink (input valid, value, bad_index, output ready);
endinterface

/* sv/expert_weight_mixer.sv */
`timescale 1ns / 1ps
// Load, query and read-weight items give a result in the result register; update and
// weight reset give none. One item at a time: the shared divider, log2 and exp units
// and the single read port of the probability store serve one item until it is done.
// Reset: the 2048-entry store is cleared one entry a cycle, with no item taken meanwhile;
// sums clear at once, weights start uniform over all experts.
module expert_weight_mixer (
    input  logic                         clk,
    input  logic                         rst_n,
    ewm_in_if.sink                       in_ch,
    ewm_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ewm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ewm_pkg::*;

    // Sequencer state
    ewm_state_t state_reg, state_next;
    logic [CNT_W-1:0]  e_reg;
    logic [CNT_W-1:0]  e_inc;
    logic              e_last;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Configuration
    logic [3:0]        experts_reg;
    logic [ETA_W-1:0]  eta_reg;
    logic [PROB_W-1:0] floor_reg;
    logic [CNT_W-1:0]  n_eff;

    // Per-expert state
    logic [PROB_W-1:0]       w_reg   [MAX_EXPERTS];
    logic signed [LW_W-1:0]  lw_reg  [MAX_EXPERTS];
    logic [SUM_W-1:0]        sum_reg [MAX_EXPERTS];
    logic [EX_W-1:0]         ex_reg  [MAX_EXPERTS];

    // Item in flight
    logic [OP_W-1:0]     op_reg;
    logic [SYMBOL_W-1:0] sym_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic                bad_reg;

    // Probability store
    logic [PROB_W-1:0] store_mem [STORE_DEPTH];
    logic [PROB_W-1:0] rdata_reg;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PROB_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // Datapath
    logic [31:0]              pnum_reg;
    logic [PROB_W+SUM_W-1:0]  pden_reg;
    logic [DIV_W-1:0]         num_acc_reg;
    logic [DIV_W-1:0]         den_acc_reg;
    logic [PROB_W-1:0]        qres_reg;
    logic [EX_W-1:0]          mag_reg;
    logic [EX_W+ETA_W-1:0]    eprod_reg;
    logic signed [LW_W-1:0]   mx_reg;
    logic [11:0]              ip_reg;
    logic [11:0]              fp_reg;
    logic [3:0]               k_reg;
    logic [32:0]              r_reg;
    logic [ESUM_W-1:0]        esum_reg;
    logic signed [LOG_W-1:0]  lsum_reg;
    logic [PROB_W-1:0]        out_value_reg;
    logic                     out_bad_reg;
    logic                     out_valid_reg;

    logic              in_ready;
    logic              accept;
    logic              out_load;
    logic [PROB_W-1:0] lik;
    logic [64:0]       rprod;
    logic [EX_W-1:0]   exval;
    logic [LW_W:0]     udiff;
    logic [EXPERT_W-1:0] ei;

    // Shared units
    logic                     log_start;
    logic [LOGX_W-1:0]        log_x;
    logic                     log_done;
    logic signed [LOG_W-1:0]  log_l;
    logic                     div_start;
    logic [DIV_W-1:0]         div_num;
    logic [DIV_W-1:0]         div_den;
    logic                     div_done;
    logic [PROB_W-1:0]        div_q;

    function automatic logic signed [LW_W-1:0] sat_lw(input logic signed [LW_W+2:0] v);
        if (v < (LW_W+3)'(LW_MIN))
        begin
            return LW_MIN;
        end else if (v > (LW_W+3)'(LW_MAX))
        begin
            return LW_MAX;
        end
        return v[LW_W-1:0];
    endfunction

    ewm_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_l)
    );

    ewm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Clamp the expert count to 1..MAX_EXPERTS.
    always_comb
    begin
        if (experts_reg == 4'd0)
        begin
            n_eff = CNT_W'(1);
        end else if (experts_reg > 4'(MAX_EXPERTS))
        begin
            n_eff = CNT_W'(MAX_EXPERTS);
        end else begin
            n_eff = CNT_W'(experts_reg);
        end
    end

    assign ei     = e_reg[EXPERT_W-1:0];
    assign e_inc  = e_reg + CNT_W'(1);
    assign e_last = (e_inc == n_eff);
    assign accept = in_ch.valid && in_ready;
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || out_ch.ready);

    // Floored likelihood; a zero floor still keeps it above zero.
    always_comb
    begin
        lik = (rdata_reg < floor_reg) ? floor_reg : rdata_reg;
        if (lik == '0)
        begin
            lik = PROB_W'(1);
        end
    end

    assign rprod = 65'(r_reg) * 65'(EXP_C[k_reg]);
    assign udiff = (LW_W+1)'(mx_reg) - (LW_W+1)'(lw_reg[ei]);
    assign exval = (ip_reg >= 12'(EX_W)) ? '0 : EX_W'(r_reg[32:16] >> ip_reg[4:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (op_t'(in_ch.op))
                        OP_LOAD:   state_next = S_LD_RD;
                        OP_QUERY:  state_next = S_Q_RD;
                        OP_UPDATE: state_next = S_U_RD;
                        OP_READ:   state_next = S_RESULT;
                        OP_RESET:  state_next = S_R_START;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LD_RD:    state_next = S_LD_WR;
            S_LD_WR:    state_next = S_RESULT;
            S_Q_RD:     state_next = S_Q_MUL;
            S_Q_MUL:    state_next = S_Q_ACC;
            S_Q_ACC:    state_next = e_last ? S_Q_DIV : S_Q_RD;
            S_Q_DIV:    state_next = S_Q_WAIT;
            S_Q_WAIT:   state_next = div_done ? S_RESULT : S_Q_WAIT;
            S_U_RD:     state_next = S_U_LOG;
            S_U_LOG:    state_next = S_U_LWAIT;
            S_U_LWAIT:  state_next = log_done ? S_U_MUL : S_U_LWAIT;
            S_U_MUL:    state_next = S_U_ADD;
            S_U_ADD:    state_next = e_last ? S_U_MAX : S_U_RD;
            S_U_MAX:    state_next = e_last ? S_U_EXP0 : S_U_MAX;
            S_U_EXP0:   state_next = S_U_EXP;
            S_U_EXP:    state_next = (k_reg == 4'(EXP_STEPS - 1)) ? S_U_EXPSH : S_U_EXP;
            S_U_EXPSH:  state_next = e_last ? S_U_LSUM : S_U_EXP0;
            S_U_LSUM:   state_next = S_U_LSWAIT;
            S_U_LSWAIT: state_next = log_done ? S_U_DIV : S_U_LSWAIT;
            S_U_DIV:    state_next = S_U_DWAIT;
            S_U_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = e_last ? S_IDLE : S_U_DIV;
                end
            end
            S_R_START:  state_next = S_R_WAIT;
            // The divider runs longer than log2, so both results are ready here.
            S_R_WAIT:   state_next = div_done ? S_IDLE : S_R_WAIT;
            S_RESULT:   state_next = out_load ? S_IDLE : S_RESULT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        mem_re    = (state_reg == S_LD_RD) || (state_reg == S_Q_RD) ||
                    (state_reg == S_U_RD);
        mem_raddr = {ei, sym_reg};
        mem_we    = 1'b0;
        mem_waddr = {ei, sym_reg};
        mem_wdata = prob_reg;
        log_start = 1'b0;
        log_x     = LOGX_W'(lik);
        div_start = 1'b0;
        div_num   = num_acc_reg;
        div_den   = den_acc_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            S_LD_WR:
            begin
                mem_we = !bad_reg;
            end
            S_Q_DIV:
            begin
                div_start = 1'b1;
            end
            S_U_LOG:
            begin
                log_start = 1'b1;
            end
            S_U_LSUM:
            begin
                log_start = 1'b1;
                log_x     = esum_reg;
            end
            S_U_DIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(ex_reg[ei]);
                div_den   = DIV_W'(esum_reg);
            end
            S_R_START:
            begin
                // 1/n as a weight, log2 of n for the log-weight
                log_start = 1'b1;
                log_x     = LOGX_W'({n_eff, {PROB_W{1'b0}}});
                div_start = 1'b1;
                div_num   = DIV_W'(1);
                div_den   = DIV_W'(n_eff);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Store: one write port, one registered read port. The sequencer never
    // reads an entry in the cycle it is written, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            e_reg         <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            experts_reg   <= 4'(MAX_EXPERTS);
            eta_reg       <= ETA_W'(4096);
            floor_reg     <= PROB_W'(1);
            for (int e = 0; e < MAX_EXPERTS; e++)
            begin
                w_reg[e]   <= W_RST;
                lw_reg[e]  <= LW_RST;
                sum_reg[e] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            // Configuration write
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_EXPERTS: experts_reg <= pwdata[3:0];
                    REG_ETA:     eta_reg     <= pwdata[ETA_W-1:0];
                    REG_FLOOR:   floor_reg   <= pwdata[PROB_W-1:0];
                    default:     experts_reg <= experts_reg;
                endcase
            end

            // Result register: drop on take, load when free or taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Expert index
            if (accept)
            begin
                if ((op_t'(in_ch.op) == OP_LOAD) || (op_t'(in_ch.op) == OP_READ))
                begin
                    e_reg <= CNT_W'(in_ch.expert);
                end else begin
                    e_reg <= '0;
                end
            end else if ((state_reg == S_Q_ACC) || (state_reg == S_U_ADD) ||
                         (state_reg == S_U_MAX) || (state_reg == S_U_EXPSH) ||
                         ((state_reg == S_U_DWAIT) && div_done))
            begin
                e_reg <= e_last ? '0 : e_inc;
            end

            case (state_reg)
                S_LD_WR:
                begin
                    if (!bad_reg)
                    begin
                        sum_reg[ei] <= sum_reg[ei] - SUM_W'(rdata_reg) + SUM_W'(prob_reg);
                    end
                end
                S_U_ADD:
                begin
                    lw_reg[ei] <= sat_lw((LW_W+3)'(lw_reg[ei]) -
                                         (LW_W+3)'(eprod_reg[EX_W+ETA_W-1:12]));
                end
                S_U_DWAIT:
                begin
                    if (div_done)
                    begin
                        w_reg[ei]  <= div_q;
                        lw_reg[ei] <= sat_lw((LW_W+3)'(lw_reg[ei]) - (LW_W+3)'(mx_reg) -
                                             (LW_W+3)'(lsum_reg));
                    end
                end
                S_R_WAIT:
                begin
                    if (div_done)
                    begin
                        for (int e = 0; e < MAX_EXPERTS; e++)
                        begin
                            if (CNT_W'(e) < n_eff)
                            begin
                                w_reg[e]  <= div_q;
                                lw_reg[e] <= LW_W'(-(LW_W+1)'(log_l));
                            end else begin
                                w_reg[e]  <= '0;
                                lw_reg[e] <= LW_MIN;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_ch.op;
            sym_reg     <= in_ch.symbol;
            prob_reg    <= in_ch.prob;
            bad_reg     <= ((op_t'(in_ch.op) == OP_LOAD) || (op_t'(in_ch.op) == OP_READ)) &&
                           (CNT_W'(in_ch.expert) >= n_eff);
            num_acc_reg <= '0;
            den_acc_reg <= '0;
            esum_reg    <= '0;
        end
        case (state_reg)
            S_Q_MUL:
            begin
                pnum_reg <= 32'(w_reg[ei]) * 32'(rdata_reg);
                pden_reg <= (PROB_W+SUM_W)'(w_reg[ei]) * (PROB_W+SUM_W)'(sum_reg[ei]);
            end
            S_Q_ACC:
            begin
                num_acc_reg <= num_acc_reg + DIV_W'(pnum_reg);
                den_acc_reg <= den_acc_reg + DIV_W'(pden_reg);
            end
            S_Q_WAIT:
            begin
                if (div_done)
                begin
                    qres_reg <= div_q;
                end
            end
            S_U_LWAIT:
            begin
                // the log of a likelihood below 1.0 is negative: keep its magnitude
                if (log_done)
                begin
                    mag_reg <= EX_W'(-log_l);
                end
            end
            S_U_MUL:
            begin
                eprod_reg <= (EX_W+ETA_W)'(eta_reg) * (EX_W+ETA_W)'(mag_reg);
            end
            S_U_MAX:
            begin
                if ((e_reg == '0) || (lw_reg[ei] > mx_reg))
                begin
                    mx_reg <= lw_reg[ei];
                end
            end
            S_U_EXP0:
            begin
                ip_reg <= udiff[23:12];
                fp_reg <= udiff[11:0];
                r_reg  <= 33'd1 << 32;
                k_reg  <= '0;
            end
            S_U_EXP:
            begin
                if (fp_reg[11])
                begin
                    r_reg <= rprod[64:32];
                end
                fp_reg <= fp_reg << 1;
                k_reg  <= k_reg + 4'd1;
            end
            S_U_EXPSH:
            begin
                ex_reg[ei] <= exval;
                esum_reg   <= esum_reg + ESUM_W'(exval);
            end
            S_U_LSWAIT:
            begin
                if (log_done)
                begin
                    lsum_reg <= log_l;
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    out_bad_reg <= bad_reg;
                    case (op_t'(op_reg))
                        OP_LOAD:  out_value_reg <= bad_reg ? '0 : prob_reg;
                        OP_QUERY: out_value_reg <= qres_reg;
                        OP_READ:  out_value_reg <= bad_reg ? '0 : w_reg[ei];
                        default:  out_value_reg <= '0;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready      = in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value     = out_value_reg;
    assign out_ch.bad_index = out_bad_reg;
    assign pready           = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_EXPERTS: prdata = 32'(experts_reg);
            REG_ETA:     prdata = 32'(eta_reg);
            REG_FLOOR:   prdata = 32'(floor_reg);
            default:     prdata = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_LD_WR))
        else $error("store written outside clear or load");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_Q_WAIT) || (state_reg == S_U_DWAIT) ||
                     (state_reg == S_R_WAIT))
        else $error("divider finished with no one waiting");

    a_log_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        log_done |-> (state_reg == S_U_LWAIT) || (state_reg == S_U_LSWAIT) ||
                     (state_reg == S_R_WAIT))
        else $error("log2 finished with no one waiting");

    a_loop_index: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_Q_RD) || (state_reg == S_U_RD) || (state_reg == S_U_DIV))
        |-> (e_reg < n_eff))
        else $error("expert loop index beyond active count");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready && !out_valid_reg)
        else $error("activity during store clear");
`endif

endmodule

/* sv/ewm_log2.sv */
`timescale 1ns / 1ps

module ewm_log2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ewm_pkg::LOGX_W-1:0]        x,
    output logic                              done,
    output logic signed [ewm_pkg::LOG_W-1:0]  result
);
    import ewm_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [30:0] m_reg;
    logic [5:0]  pm_reg;
    logic [11:0] frac_reg;
    logic [4:0]  msb;
    logic [61:0] sq;
    logic [31:0] ms;

    // Leading one position.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < LOGX_W; i++)
        begin
            if (x[i])
            begin
                msb = 5'(i);
            end
        end
    end

    assign sq = 62'(m_reg) * 62'(m_reg);
    assign ms = sq[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 4'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(EXP_STEPS - 1);
            end else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Square the mantissa; each overflow past 2.0 yields one fraction bit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg    <= 31'(x) << (5'd30 - msb);
            pm_reg   <= 6'({1'b0, msb}) - 6'd16;
            frac_reg <= '0;
        end else if (busy_reg)
        begin
            frac_reg <= {frac_reg[10:0], ms[31]};
            m_reg    <= ms[31] ? ms[31:1] : ms[30:0];
        end
    end

    assign done   = done_reg;
    assign result = {pm_reg, frac_reg};

endmodule

/* sv/ewm_div.sv */
`timescale 1ns / 1ps

module ewm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ewm_pkg::DIV_W-1:0]   num,
    input  logic [ewm_pkg::DIV_W-1:0]   den,
    output logic                        done,
    output logic [ewm_pkg::PROB_W-1:0]  quot
);
    import ewm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DIV_W:0]    rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [PROB_W:0]   q_reg;
    logic              ge;
    logic [DIV_W:0]    diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = rem_reg - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(PROB_W);
            end else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Restoring division of num * 2^16 by den, one quotient bit a cycle;
    // num never exceeds den, so 17 bits cover the quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg)
        begin
            q_reg   <= {q_reg[PROB_W-1:0], ge};
            rem_reg <= (ge ? diff : rem_reg) << 1;
        end
    end

    always_comb
    begin
        if (den_reg == '0)
        begin
            quot = '0;
        end else if (q_reg[PROB_W])
        begin
            quot = {PROB_W{1'b1}};
        end else begin
            quot = q_reg[PROB_W-1:0];
        end
    end

    assign done = done_reg;

endmodule
